// ----- src/ppdof_pkg.sv -----
`timescale 1ns / 1ps

package ppdof_pkg;

    localparam int unsigned BIN_COUNT   = 64;
    localparam int unsigned TAG_W       = $clog2(BIN_COUNT);
    localparam int unsigned RADIUS_W    = 20;
    localparam int unsigned SPEED_W     = 17;
    localparam int unsigned RT_W        = 16;
    localparam int unsigned DOF_W       = 28;

    localparam logic [RT_W-1:0] RT_RESET = 16'd256;

    localparam int unsigned S_DIV1_LAST  = 31;
    localparam int unsigned S_DIV2_SET   = 32;
    localparam int unsigned S_DIV2_LAST  = 53;
    localparam int unsigned S_Y          = 54;
    localparam int unsigned S_TAB        = 55;
    localparam int unsigned S_FRAC       = 56;
    localparam int unsigned S_DIV3_SET   = 57;
    localparam int unsigned S_DIV3_LAST  = 80;
    localparam int unsigned S_F          = 81;
    localparam int unsigned S_P2         = 82;
    localparam int unsigned S_Z          = 83;
    localparam int unsigned S_A          = 84;
    localparam int unsigned S_PP         = 85;
    localparam int unsigned S_DOF        = 86;
    localparam int unsigned STAGES       = 87;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [RADIUS_W-1:0] r;
        logic [30:0]         nm;
        logic [16:0]         rm;
        logic [16:0]         dv;
        logic [30:0]         qt;
        logic                xsat;
        logic [21:0]         y;
        logic [16:0]         hi;
        logic [23:0]         dp;
        logic [5:0]          n;
        logic [16:0]         frac;
        logic                pass;
        logic [22:0]         f;
        logic [29:0]         f2;
        logic [22:0]         p1;
        logic [21:0]         p2;
        logic [23:0]         r2;
        logic [22:0]         z;
        logic [33:0]         a;
        logic [40:0]         plo;
        logic [40:0]         phi;
        logic [DOF_W-1:0]    dof;
    } t_stage;

    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    function automatic t_stage stage_first(input logic [TAG_W-1:0] tag,
                                           input logic [RADIUS_W-1:0] r,
                                           input logic [SPEED_W-1:0] v);
        t_stage      b;
        logic [21:0] szz;
        logic [31:0] num;
        b    = '0;
        szz  = {1'b0, r, 1'b0} + 22'd524;
        num  = 32'(szz) * 32'd1000;
        b.tag = tag;
        b.r   = r;
        b.nm  = num[30:0];
        b.dv  = (v == '0) ? 17'd1 : v;
        return b;
    endfunction

    function automatic t_stage stage_next(input int unsigned s, input t_stage a,
                                          input logic [RT_W-1:0] rt);
        t_stage             b;
        logic [17:0]        rem2;
        logic [15:0]        rtn;
        logic [37:0]        py;
        logic [16:0]        lo;
        logic [16:0]        val;
        logic [16:0]        e;
        logic [20:0]        f10;
        logic [45:0]        pf2;
        logic [46:0]        pm1;
        logic [53:0]        pm2;
        logic [39:0]        pr2;
        logic signed [25:0] zs;
        logic [57:0]        sum;
        b   = a;
        rtn = (rt == '0) ? 16'd1 : rt;
        if (s <= S_DIV1_LAST || (s > S_DIV2_SET && s <= S_DIV2_LAST)
            || (s > S_DIV3_SET && s <= S_DIV3_LAST)) begin
            rem2 = {a.rm, a.nm[30]};
            b.nm = {a.nm[29:0], 1'b0};
            if (rem2 >= {1'b0, a.dv}) begin
                rem2 = rem2 - {1'b0, a.dv};
                b.qt = {a.qt[29:0], 1'b1};
            end else begin
                b.qt = {a.qt[29:0], 1'b0};
            end
            b.rm = rem2[16:0];
        end else if (s == S_DIV2_SET) begin
            b.xsat = (a.qt[30:5] >= {10'd0, rtn});
            b.rm   = {1'b0, a.qt[20:5]};
            b.nm   = {a.qt[4:0], 26'd0};
            b.dv   = {1'b0, rtn};
            b.qt   = '0;
        end else if (s == S_Y) begin
            py  = 38'(a.qt[20:0]) * 38'd94548;
            b.y = py[37:16];
        end else if (s == S_TAB) begin
            b.n  = a.y[21:16];
            b.hi = pow2_neg({1'b0, a.y[15:12]});
            lo   = pow2_neg(5'({1'b0, a.y[15:12]}) + 5'd1);
            b.dp = 24'(b.hi - lo) * 24'(a.y[11:0]);
        end else if (s == S_FRAC) begin
            val = a.hi - 17'(a.dp[23:12]);
            if (a.xsat || a.n >= 6'd32) begin
                e = '0;
            end else begin
                e = val >> a.n;
            end
            b.frac = 17'd65536 - e;
            f10    = 21'(b.frac) * 21'd10;
            b.pass = (f10 >= 21'd458752);
        end else if (s == S_DIV3_SET) begin
            b.rm = 17'd35840;
            b.nm = '0;
            b.dv = a.frac;
            b.qt = '0;
        end else if (s == S_F) begin
            b.f  = a.qt[22:0];
            pf2  = 46'(b.f) * 46'(b.f);
            b.f2 = pf2[45:16];
            pm1  = 47'd10536092 * 47'(b.f);
            b.p1 = pm1[46:24];
            pr2  = 40'(a.r) * 40'(a.r);
            b.r2 = pr2[39:16];
        end else if (s == S_P2) begin
            pm2  = 54'd13941464 * 54'(a.f2);
            b.p2 = pm2[53:32];
        end else if (s == S_Z) begin
            zs  = 26'sd1996227 + $signed({4'd0, a.p2}) - $signed({3'd0, a.p1});
            b.z = (zs < 0) ? '0 : zs[22:0];
        end else if (s == S_A) begin
            b.a = 34'd1580 * 34'(a.z);
        end else if (s == S_PP) begin
            b.plo = 41'(a.a[16:0]) * 41'(a.r2);
            b.phi = 41'(a.a[33:17]) * 41'(a.r2);
        end else if (s == S_DOF) begin
            sum = {a.phi, 17'd0} + 58'(a.plo);
            if (!a.pass) begin
                b.dof = '0;
            end else if (sum[57:52] != '0) begin
                b.dof = '1;
            end else begin
                b.dof = sum[51:24];
            end
        end
        return b;
    endfunction

endpackage

// ----- src/ppdof_if.sv -----
`timescale 1ns / 1ps

interface ppdof_in_if;
    logic                             valid;
    logic                             ready;
    logic [ppdof_pkg::TAG_W-1:0]      bin_index;
    logic [ppdof_pkg::RADIUS_W-1:0]   bin_radius;
    logic [ppdof_pkg::SPEED_W-1:0]    airspeed;
    modport source (output valid, output bin_index, output bin_radius, output airspeed,
                    input ready);
    modport sink (input valid, input bin_index, input bin_radius, input airspeed,
                  output ready);
endinterface

interface ppdof_out_if;
    logic                             valid;
    logic                             ready;
    logic [ppdof_pkg::TAG_W-1:0]      bin_tag;
    logic [ppdof_pkg::DOF_W-1:0]      depth_of_field;
    logic                             occulted_enough;
    modport source (output valid, output bin_tag, output depth_of_field,
                    output occulted_enough, input ready);
    modport sink (input valid, input bin_tag, input depth_of_field,
                  input occulted_enough, output ready);
endinterface

interface ppdof_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ppdof_pkg::RT_W-1:0]       data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/ppdof_pipe.sv -----
`timescale 1ns / 1ps

module ppdof_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  ppdof_pkg::t_stage            i_item,
    input  logic [ppdof_pkg::RT_W-1:0]   i_rt,
    output logic                         o_vld,
    output ppdof_pkg::t_stage            o_item
);

    logic              r_vld [ppdof_pkg::STAGES];
    ppdof_pkg::t_stage r_st  [ppdof_pkg::STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_st[0] <= i_item;
        end
    end

    for (genvar s = 1; s < ppdof_pkg::STAGES; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (i_en) begin
                r_st[s] <= ppdof_pkg::stage_next(s, r_st[s-1], i_rt);
            end
        end
    end

    assign o_vld  = r_vld[ppdof_pkg::STAGES-1];
    assign o_item = r_st[ppdof_pkg::STAGES-1];

endmodule

// ----- src/particle_probe_depth_of_field_core.sv -----
`timescale 1ns / 1ps

// Depth of field per size bin for a one-dimensional optical probe. One bin may
// be transferred every cycle while no finished result waits on the output. Each
// result passes through the pipeline stages in order. The pipeline depth is
// set by the one-bit-per-stage dividers for transit time, normalised transit and
// the 70/frac ratio, and by the multiplier stages that follow them. The whole
// pipeline holds while a finished result waits on the output. The response time
// is written through the configuration channel, which is always ready; write it
// only while no bins are in flight.

module particle_probe_depth_of_field_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ppdof_cfg_if.sink        i_cfg,
    ppdof_in_if.sink         i_bin,
    ppdof_out_if.source      o_res
);

    logic [ppdof_pkg::RT_W-1:0] r_rt;
    logic                       en;
    logic                       last_vld;
    ppdof_pkg::t_stage          first_item;
    ppdof_pkg::t_stage          last_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt <= ppdof_pkg::RT_RESET;
        end else if (i_cfg.valid) begin
            r_rt <= i_cfg.data;
        end
    end

    assign en          = !last_vld || o_res.ready;
    assign i_bin.ready = en;
    assign first_item  = ppdof_pkg::stage_first(i_bin.bin_index, i_bin.bin_radius,
                                                i_bin.airspeed);

    ppdof_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_bin.valid),
        .i_item  (first_item),
        .i_rt    (r_rt),
        .o_vld   (last_vld),
        .o_item  (last_item)
    );

    assign o_res.valid           = last_vld;
    assign o_res.bin_tag         = last_item.tag;
    assign o_res.depth_of_field  = last_item.dof;
    assign o_res.occulted_enough = last_item.pass;

endmodule
